[hdl/aps_pkg.sv]
`default_nettype none

package aps_pkg;

	// Default operand and variable widths
	localparam int DEFAULT_VALUE_BITS = 32;
	localparam int DEFAULT_VAR_BITS   = 16;

	// Statement kind on the input side
	typedef enum logic [1:0] {
		CMD_ARITH  = 2'd0,
		CMD_ASSIGN = 2'd1,
		CMD_OTHER  = 2'd2
	} cmd_t;

	// Operator encoding, shared by input and result
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Statement kind on the result side
	typedef enum logic [1:0] {
		KIND_ARITH   = 2'd0,
		KIND_ASSIGN  = 2'd1,
		KIND_REMOVED = 2'd2,
		KIND_OTHER   = 2'd3
	} kind_t;

endpackage

`default_nettype wire

[hdl/aps_stmt_if.sv]
`default_nettype none

// Statement channel: one three-address statement per transfer
interface aps_stmt_if #(
	parameter int VALUE_BITS = 32,
	parameter int VAR_BITS   = 16
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   command;
	logic [1:0]                   op;
	logic [VAR_BITS-1:0]          dst_var;
	logic                         a_is_const;
	logic signed [VALUE_BITS-1:0] a_val;
	logic                         b_is_const;
	logic signed [VALUE_BITS-1:0] b_val;

	modport source (
		output valid, command, op, dst_var, a_is_const, a_val, b_is_const, b_val,
		input  ready
	);

	modport sink (
		input  valid, command, op, dst_var, a_is_const, a_val, b_is_const, b_val,
		output ready
	);
endinterface

`default_nettype wire

[hdl/aps_rslt_if.sv]
`default_nettype none

// Result channel: one rewritten statement per transfer
interface aps_rslt_if #(
	parameter int VALUE_BITS = 32,
	parameter int VAR_BITS   = 16
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   out_kind;
	logic [1:0]                   out_op;
	logic [VAR_BITS-1:0]          out_dst;
	logic                         out_a_is_const;
	logic signed [VALUE_BITS-1:0] out_a_val;
	logic                         out_b_is_const;
	logic signed [VALUE_BITS-1:0] out_b_val;
	logic                         changed;

	modport source (
		output valid, out_kind, out_op, out_dst, out_a_is_const, out_a_val,
		       out_b_is_const, out_b_val, changed,
		input  ready
	);

	modport sink (
		input  valid, out_kind, out_op, out_dst, out_a_is_const, out_a_val,
		       out_b_is_const, out_b_val, changed,
		output ready
	);
endinterface

`default_nettype wire

[hdl/aps_rules.sv]
`default_nettype none

// Rewrite rules for one statement, purely combinational
module aps_rules import aps_pkg::*; #(
	parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
	parameter int VAR_BITS   = DEFAULT_VAR_BITS
) (
	input  wire logic [1:0]            command,
	input  wire logic [1:0]            op,
	input  wire logic [VAR_BITS-1:0]   dst,
	input  wire logic                  a_c,
	input  wire logic [VALUE_BITS-1:0] a_v,
	input  wire logic                  b_c,
	input  wire logic [VALUE_BITS-1:0] b_v,
	output logic      [1:0]            r_kind,
	output logic      [1:0]            r_op,
	output logic                       r_a_c,
	output logic      [VALUE_BITS-1:0] r_a_v,
	output logic                       r_b_c,
	output logic      [VALUE_BITS-1:0] r_b_v,
	output logic                       r_chg
);

	localparam int CMP_BITS = (VALUE_BITS > VAR_BITS) ? VALUE_BITS : VAR_BITS;

	localparam logic [VALUE_BITS-1:0] K_ZERO  = '0;
	localparam logic [VALUE_BITS-1:0] K_ONE   = VALUE_BITS'(1);
	localparam logic [VALUE_BITS-1:0] K_TWO   = VALUE_BITS'(2);
	localparam logic [VALUE_BITS-1:0] K_MINUS = '1;

	// Operand classification
	logic a_zero, a_one, a_two, a_m1, a_neg;
	logic b_zero, b_one, b_two, b_m1, b_neg;
	logic same_var;
	logic [VALUE_BITS-1:0] a_negv, b_negv;

	assign a_zero   = a_c && (a_v == K_ZERO);
	assign a_one    = a_c && (a_v == K_ONE);
	assign a_two    = a_c && (a_v == K_TWO);
	assign a_m1     = a_c && (a_v == K_MINUS);
	assign a_neg    = a_c && a_v[VALUE_BITS-1];
	assign b_zero   = b_c && (b_v == K_ZERO);
	assign b_one    = b_c && (b_v == K_ONE);
	assign b_two    = b_c && (b_v == K_TWO);
	assign b_m1     = b_c && (b_v == K_MINUS);
	assign b_neg    = b_c && b_v[VALUE_BITS-1];
	assign same_var = !a_c && !b_c && (a_v == b_v);

	// Two's complement negation, wraps on the most negative value
	assign a_negv = K_ZERO - a_v;
	assign b_negv = K_ZERO - b_v;

	// Rule selection
	always_comb begin
		logic                  to_assign;
		logic                  src_c;
		logic [VALUE_BITS-1:0] src_v;

		to_assign = 1'b0;
		src_c     = a_c;
		src_v     = a_v;
		r_kind    = KIND_ARITH;
		r_op      = op;
		r_a_c     = a_c;
		r_a_v     = a_v;
		r_b_c     = b_c;
		r_b_v     = b_v;
		r_chg     = 1'b0;

		unique case (command)
			CMD_ARITH: begin
				unique case (op)
					OP_ADD: begin
						if (a_zero) begin
							to_assign = 1'b1; src_c = b_c; src_v = b_v;
						end else if (b_zero) begin
							to_assign = 1'b1;
						end else if (a_neg) begin
							r_a_c = b_c; r_a_v = b_v;
							r_b_c = 1'b1; r_b_v = a_negv;
							r_op  = OP_SUB; r_chg = 1'b1;
						end else if (b_neg) begin
							r_b_c = 1'b1; r_b_v = b_negv;
							r_op  = OP_SUB; r_chg = 1'b1;
						end
					end
					OP_SUB: begin
						if (b_zero) begin
							to_assign = 1'b1;
						end else if (same_var) begin
							to_assign = 1'b1; src_c = 1'b1; src_v = K_ZERO;
						end else if (b_neg) begin
							r_b_c = 1'b1; r_b_v = b_negv;
							r_op  = OP_ADD; r_chg = 1'b1;
						end
					end
					OP_MUL: begin
						if (a_one) begin
							to_assign = 1'b1; src_c = b_c; src_v = b_v;
						end else if (b_one) begin
							to_assign = 1'b1;
						end else if (a_two) begin
							r_a_c = b_c; r_a_v = b_v;
							r_op  = OP_ADD; r_chg = 1'b1;
						end else if (b_two) begin
							r_b_c = a_c; r_b_v = a_v;
							r_op  = OP_ADD; r_chg = 1'b1;
						end else if (a_m1) begin
							r_a_c = 1'b1; r_a_v = K_ZERO;
							r_op  = OP_SUB; r_chg = 1'b1;
						end else if (b_m1) begin
							r_b_c = a_c; r_b_v = a_v;
							r_a_c = 1'b1; r_a_v = K_ZERO;
							r_op  = OP_SUB; r_chg = 1'b1;
						end else if (a_zero || b_zero) begin
							to_assign = 1'b1; src_c = 1'b1; src_v = K_ZERO;
						end
					end
					OP_DIV: begin
						if (b_one) begin
							to_assign = 1'b1;
						end else if (b_m1) begin
							r_b_c = a_c; r_b_v = a_v;
							r_a_c = 1'b1; r_a_v = K_ZERO;
							r_op  = OP_SUB; r_chg = 1'b1;
						end else if (same_var) begin
							to_assign = 1'b1; src_c = 1'b1; src_v = K_ONE;
						end else if (b_zero || a_zero) begin
							to_assign = 1'b1; src_c = 1'b1; src_v = K_ZERO;
						end
					end
				endcase
				if (to_assign) r_chg = 1'b1;
			end
			CMD_ASSIGN: begin
				to_assign = 1'b1;
			end
			default: begin
				// other or unknown statements pass through untouched
				r_kind = KIND_OTHER;
			end
		endcase

		// Assign form, with self-assignment removal
		if (to_assign) begin
			r_kind = KIND_ASSIGN;
			r_op   = OP_ADD;
			r_a_c  = src_c;
			r_a_v  = src_v;
			r_b_c  = 1'b0;
			r_b_v  = K_ZERO;
			if (!src_c && (CMP_BITS'(src_v) == CMP_BITS'(dst))) begin
				r_kind = KIND_REMOVED;
				r_chg  = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/arith_peephole_simplifier.sv]
// Channel  Dir  Interface    Carries
// -------  ---  -----------  ------------------------------------------
// req      in   aps_stmt_if  statement: kind, op, dst, two operands
// rsp      out  aps_rslt_if  rewritten statement and changed flag
//
// One statement per cycle sustained while rsp is ready; a result passes
// through the input register, rule logic and result register.
// Both registers advance whenever the result register is empty or is taken,
// so ready on req follows the result side combinationally.
// arst_n clears the two valid flags; payload registers are not reset.
// A stall on rsp holds the result and backs up one more item in the input
// register before req drops ready.
`default_nettype none

module arith_peephole_simplifier import aps_pkg::*; #(
	parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
	parameter int VAR_BITS   = DEFAULT_VAR_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	aps_stmt_if.sink   req,
	aps_rslt_if.source rsp
);

	// Input register
	logic                  v_s1;
	logic [1:0]            cmd_s1;
	logic [1:0]            op_s1;
	logic [VAR_BITS-1:0]   dst_s1;
	logic                  a_c_s1;
	logic [VALUE_BITS-1:0] a_v_s1;
	logic                  b_c_s1;
	logic [VALUE_BITS-1:0] b_v_s1;

	// Result register
	logic                  v_s2;
	logic [1:0]            kind_s2;
	logic [1:0]            op_s2;
	logic [VAR_BITS-1:0]   dst_s2;
	logic                  a_c_s2;
	logic [VALUE_BITS-1:0] a_v_s2;
	logic                  b_c_s2;
	logic [VALUE_BITS-1:0] b_v_s2;
	logic                  chg_s2;

	// Rule outputs
	logic [1:0]            r_kind;
	logic [1:0]            r_op;
	logic                  r_a_c;
	logic [VALUE_BITS-1:0] r_a_v;
	logic                  r_b_c;
	logic [VALUE_BITS-1:0] r_b_v;
	logic                  r_chg;

	logic adv_s2;
	logic adv_s1;

	// Stage advance
	assign adv_s2    = !v_s2 || rsp.ready;
	assign adv_s1    = !v_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			cmd_s1 <= req.command;
			op_s1  <= req.op;
			dst_s1 <= req.dst_var;
			a_c_s1 <= req.a_is_const;
			a_v_s1 <= $unsigned(req.a_val);
			b_c_s1 <= req.b_is_const;
			b_v_s1 <= $unsigned(req.b_val);
		end
	end

	aps_rules #(
		.VALUE_BITS (VALUE_BITS),
		.VAR_BITS   (VAR_BITS)
	) u_rules (
		.command (cmd_s1),
		.op      (op_s1),
		.dst     (dst_s1),
		.a_c     (a_c_s1),
		.a_v     (a_v_s1),
		.b_c     (b_c_s1),
		.b_v     (b_v_s1),
		.r_kind  (r_kind),
		.r_op    (r_op),
		.r_a_c   (r_a_c),
		.r_a_v   (r_a_v),
		.r_b_c   (r_b_c),
		.r_b_v   (r_b_v),
		.r_chg   (r_chg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			kind_s2 <= r_kind;
			op_s2   <= r_op;
			dst_s2  <= dst_s1;
			a_c_s2  <= r_a_c;
			a_v_s2  <= r_a_v;
			b_c_s2  <= r_b_c;
			b_v_s2  <= r_b_v;
			chg_s2  <= r_chg;
		end
	end

	// Result drive
	assign rsp.valid          = v_s2;
	assign rsp.out_kind       = kind_s2;
	assign rsp.out_op         = op_s2;
	assign rsp.out_dst        = dst_s2;
	assign rsp.out_a_is_const = a_c_s2;
	assign rsp.out_a_val      = $signed(a_v_s2);
	assign rsp.out_b_is_const = b_c_s2;
	assign rsp.out_b_val      = $signed(b_v_s2);
	assign rsp.changed        = chg_s2;

`ifndef SYNTHESIS
	// A removed statement always counts as a rewrite
	a_removed_changed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.out_kind == KIND_REMOVED) |-> rsp.changed)
		else $error("removed statement without changed flag");

	// Passed-through statements are never flagged
	a_other_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.out_kind == KIND_OTHER) |-> !rsp.changed)
		else $error("other statement flagged as changed");

	// Assign and removed results carry a cleared second operand
	a_assign_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && ((rsp.out_kind == KIND_ASSIGN) || (rsp.out_kind == KIND_REMOVED))
		|-> (rsp.out_op == OP_ADD) && !rsp.out_b_is_const && (rsp.out_b_val == '0))
		else $error("assign result with stray operator or operand");

	// An item in the input register moves on when the result side is free
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_s2 |=> v_s2)
		else $error("item lost between input and result register");
`endif

endmodule

`default_nettype wire

[tb/tb_arith_peephole_simplifier.sv]
`timescale 1ns / 100ps

module tb_arith_peephole_simplifier;
	import aps_pkg::*;

	localparam int VB  = DEFAULT_VALUE_BITS;
	localparam int VRB = DEFAULT_VAR_BITS;

	// input kind code outside the package enum, passed through like other
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	localparam int N_RANDOM       = 950;
	localparam int QUIET_TAIL     = 150;
	localparam int HOLD_AT        = 300;
	localparam int DRAIN_AT       = 500;
	localparam int HOLD_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 1000;

	localparam logic [31:0] C_MINUS1 = 32'hFFFF_FFFF;
	localparam logic [31:0] C_MIN    = 32'h8000_0000;
	localparam logic [31:0] C_MAX    = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [1:0]  op;
		logic [15:0] dst;
		logic        a_c;
		logic [31:0] a_v;
		logic        b_c;
		logic [31:0] b_v;
	} stmt_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  op;
		logic [15:0] dst;
		logic        a_c;
		logic [31:0] a_v;
		logic        b_c;
		logic [31:0] b_v;
		logic        chg;
	} rslt_t;

	typedef struct packed {
		stmt_t s;
		logic  typed;
		rslt_t want;
	} row_t;

	logic clk;
	logic arst_n;

	aps_stmt_if #(.VALUE_BITS(VB), .VAR_BITS(VRB)) req_if ();
	aps_rslt_if #(.VALUE_BITS(VB), .VAR_BITS(VRB)) rsp_if ();

	arith_peephole_simplifier #(.VALUE_BITS(VB), .VAR_BITS(VRB)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	rslt_t want_q[$];
	row_t  stim_rows[$];

	logic quiet    = 1'b0;
	logic hold_req = 1'b0;
	int   hold_left  = 0;
	int   stall_left = 0;
	int   idle_cnt   = 0;

	int n_sent = 0, n_directed = 0, n_checked = 0, n_errors = 0;
	int n_arith = 0, n_assign = 0, n_removed = 0, n_other = 0, n_changed = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic stmt_t mk(logic [1:0] cmd, logic [1:0] op, logic [15:0] dst,
			logic ac, logic [31:0] av, logic bc, logic [31:0] bv);
		stmt_t s;
		s = '{cmd, op, dst, ac, av, bc, bv};
		return s;
	endfunction

	function automatic rslt_t mkr(logic [1:0] kind, logic [1:0] op, logic [15:0] dst,
			logic ac, logic [31:0] av, logic bc, logic [31:0] bv, logic chg);
		rslt_t r;
		r = '{kind, op, dst, ac, av, bc, bv, chg};
		return r;
	endfunction

	function automatic logic const_is(logic c, logic [31:0] v, logic [31:0] k);
		return c && (v == k);
	endfunction

	// rewrite one statement; rules tried in order, first hit wins
	function automatic rslt_t simplify(stmt_t s);
		rslt_t       r;
		logic        to_assign;
		logic        chg;
		logic        src_c;
		logic [31:0] src_v;
		logic        same_var;
		r = '{KIND_ARITH, s.op, s.dst, s.a_c, s.a_v, s.b_c, s.b_v, 1'b0};
		to_assign = 1'b0;
		chg = 1'b0;
		src_c = s.a_c;
		src_v = s.a_v;
		same_var = !s.a_c && !s.b_c && (s.a_v == s.b_v);
		case (s.command)
			CMD_ARITH: begin
				case (s.op)
					OP_ADD: begin
						if (const_is(s.a_c, s.a_v, 0)) begin
							to_assign = 1'b1; src_c = s.b_c; src_v = s.b_v;
						end else if (const_is(s.b_c, s.b_v, 0)) begin
							to_assign = 1'b1;
						end else if (s.a_c && s.a_v[31]) begin
							r.a_c = s.b_c; r.a_v = s.b_v;
							r.b_c = 1'b1; r.b_v = 32'd0 - s.a_v;
							r.op = OP_SUB; chg = 1'b1;
						end else if (s.b_c && s.b_v[31]) begin
							r.b_v = 32'd0 - s.b_v; r.op = OP_SUB; chg = 1'b1;
						end
					end
					OP_SUB: begin
						if (const_is(s.b_c, s.b_v, 0)) begin
							to_assign = 1'b1;
						end else if (same_var) begin
							to_assign = 1'b1; src_c = 1'b1; src_v = 32'd0;
						end else if (s.b_c && s.b_v[31]) begin
							r.b_v = 32'd0 - s.b_v; r.op = OP_ADD; chg = 1'b1;
						end
					end
					OP_MUL: begin
						if (const_is(s.a_c, s.a_v, 1)) begin
							to_assign = 1'b1; src_c = s.b_c; src_v = s.b_v;
						end else if (const_is(s.b_c, s.b_v, 1)) begin
							to_assign = 1'b1;
						end else if (const_is(s.a_c, s.a_v, 2)) begin
							r.a_c = s.b_c; r.a_v = s.b_v; r.op = OP_ADD; chg = 1'b1;
						end else if (const_is(s.b_c, s.b_v, 2)) begin
							r.b_c = s.a_c; r.b_v = s.a_v; r.op = OP_ADD; chg = 1'b1;
						end else if (const_is(s.a_c, s.a_v, C_MINUS1)) begin
							r.a_c = 1'b1; r.a_v = 32'd0; r.op = OP_SUB; chg = 1'b1;
						end else if (const_is(s.b_c, s.b_v, C_MINUS1)) begin
							r.b_c = s.a_c; r.b_v = s.a_v;
							r.a_c = 1'b1; r.a_v = 32'd0; r.op = OP_SUB; chg = 1'b1;
						end else if (const_is(s.a_c, s.a_v, 0)
								|| const_is(s.b_c, s.b_v, 0)) begin
							to_assign = 1'b1; src_c = 1'b1; src_v = 32'd0;
						end
					end
					default: begin
						if (const_is(s.b_c, s.b_v, 1)) begin
							to_assign = 1'b1;
						end else if (const_is(s.b_c, s.b_v, C_MINUS1)) begin
							r.b_c = s.a_c; r.b_v = s.a_v;
							r.a_c = 1'b1; r.a_v = 32'd0; r.op = OP_SUB; chg = 1'b1;
						end else if (same_var) begin
							to_assign = 1'b1; src_c = 1'b1; src_v = 32'd1;
						end else if (const_is(s.b_c, s.b_v, 0)
								|| const_is(s.a_c, s.a_v, 0)) begin
							to_assign = 1'b1; src_c = 1'b1; src_v = 32'd0;
						end
					end
				endcase
				if (to_assign)
					chg = 1'b1;
			end
			CMD_ASSIGN: to_assign = 1'b1;
			default: r.kind = KIND_OTHER;
		endcase
		// assign form; a variable copied onto itself is dropped
		if (to_assign) begin
			r.kind = KIND_ASSIGN;
			r.op = OP_ADD;
			r.a_c = src_c;
			r.a_v = src_v;
			r.b_c = 1'b0;
			r.b_v = 32'd0;
			if (!src_c && src_v == {16'd0, s.dst}) begin
				r.kind = KIND_REMOVED;
				chg = 1'b1;
			end
		end
		r.chg = chg;
		return r;
	endfunction

	// operand biased toward the constants and variables the rules look for
	function automatic void pick_operand(input logic [15:0] dst, output logic c,
			output logic [31:0] v);
		c = 1'b1;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				case ($urandom_range(0, 7))
					0: v = 32'd0;
					1: v = 32'd1;
					2: v = 32'd2;
					3: v = C_MINUS1;
					4: v = C_MIN;
					5: v = C_MAX;
					6: v = $urandom | C_MIN;
					default: v = $urandom;
				endcase
			end
			4: v = $urandom;
			5, 6: begin c = 1'b0; v = $urandom_range(0, 7); end
			7: begin c = 1'b0; v = {16'd0, dst}; end
			8: begin c = 1'b0; v = $urandom; end
			default: begin
				c = 1'b0;
				v = {($urandom_range(0, 1) ? 16'hFFFF : 16'h0001), dst};
			end
		endcase
	endfunction

	function automatic stmt_t rand_stmt();
		stmt_t s;
		int    k;
		k = $urandom_range(0, 19);
		if (k < 14)
			s.command = CMD_ARITH;
		else if (k < 17)
			s.command = CMD_ASSIGN;
		else if (k < 19)
			s.command = CMD_OTHER;
		else
			s.command = CMD_UNKNOWN;
		s.op = 2'($urandom_range(0, 3));
		s.dst = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom_range(0, 65535));
		pick_operand(s.dst, s.a_c, s.a_v);
		pick_operand(s.dst, s.b_c, s.b_v);
		// same operand on both sides now and then
		if ($urandom_range(0, 5) == 0) begin
			s.b_c = s.a_c;
			s.b_v = s.a_v;
		end
		return s;
	endfunction

	function automatic string fmt_rslt(rslt_t r);
		return $sformatf("kind=%0d op=%0d dst=%0d a=%0d:%h b=%0d:%h chg=%0d",
			r.kind, r.op, r.dst, r.a_c, r.a_v, r.b_c, r.b_v, r.chg);
	endfunction

	// offer one statement; expectation queued at the transfer
	task automatic push_stmt(input stmt_t s, input logic typed, input rslt_t typed_want);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 10);
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid      = 1'b1;
		req_if.command    = s.command;
		req_if.op         = s.op;
		req_if.dst_var    = s.dst;
		req_if.a_is_const = s.a_c;
		req_if.a_val      = s.a_v;
		req_if.b_is_const = s.b_c;
		req_if.b_val      = s.b_v;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		want_q.push_back(typed ? typed_want : simplify(s));
		n_sent++;
		@(negedge clk);
	endtask

	// result side ready: random stall bursts, plus one long hold-off
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (!arst_n) begin
				rsp_if.ready = 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				rsp_if.ready = 1'b0;
			end else begin
				rsp_if.ready = 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rslt_t got;
		rslt_t want;
		string bad;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.kind = rsp_if.out_kind;
			got.op   = rsp_if.out_op;
			got.dst  = rsp_if.out_dst;
			got.a_c  = rsp_if.out_a_is_const;
			got.a_v  = rsp_if.out_a_val;
			got.b_c  = rsp_if.out_b_is_const;
			got.b_v  = rsp_if.out_b_val;
			got.chg  = rsp_if.changed;
			if (want_q.size() == 0) begin
				n_errors++;
				$display("%0t: result with none pending: expected none, actual %s",
					$time, fmt_rslt(got));
			end else begin
				want = want_q.pop_front();
				n_checked++;
				bad = "";
				if (got.kind !== want.kind) bad = {bad, " kind"};
				if (got.op   !== want.op)   bad = {bad, " op"};
				if (got.dst  !== want.dst)  bad = {bad, " dst"};
				if (got.a_c  !== want.a_c)  bad = {bad, " a_is_const"};
				if (got.a_v  !== want.a_v)  bad = {bad, " a_val"};
				if (got.b_c  !== want.b_c)  bad = {bad, " b_is_const"};
				if (got.b_v  !== want.b_v)  bad = {bad, " b_val"};
				if (got.chg  !== want.chg)  bad = {bad, " changed"};
				if (bad != "") begin
					n_errors++;
					$display("%0t: wrong%s: expected %s, actual %s",
						$time, bad, fmt_rslt(want), fmt_rslt(got));
				end
				case (want.kind)
					KIND_ARITH:   n_arith++;
					KIND_ASSIGN:  n_assign++;
					KIND_REMOVED: n_removed++;
					default:      n_other++;
				endcase
				if (want.chg)
					n_changed++;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results pending",
				$time, idle_cnt, want_q.size());
			$display("arith_peephole_simplifier: mismatch");
			$finish;
		end
	end

	// stimulus
	initial begin
		int i;
		arst_n = 1'b0;
		req_if.valid      = 1'b0;
		req_if.command    = CMD_ARITH;
		req_if.op         = OP_ADD;
		req_if.dst_var    = '0;
		req_if.a_is_const = 1'b0;
		req_if.a_val      = '0;
		req_if.b_is_const = 1'b0;
		req_if.b_val      = '0;

		// directed table: typed expectation where it is obvious, else predicted
		// pass-through of other and unknown kinds, field extremes
		stim_rows.push_back('{mk(CMD_OTHER, OP_DIV, 16'hFFFF, 1'b1, C_MIN, 1'b0, C_MAX), 1'b1,
			mkr(KIND_OTHER, OP_DIV, 16'hFFFF, 1'b1, C_MIN, 1'b0, C_MAX, 1'b0)});
		stim_rows.push_back('{mk(CMD_UNKNOWN, OP_MUL, 16'h0000, 1'b0, 32'd0, 1'b1, C_MINUS1), 1'b1,
			mkr(KIND_OTHER, OP_MUL, 16'h0000, 1'b0, 32'd0, 1'b1, C_MINUS1, 1'b0)});
		// plain assign ignores the second operand
		stim_rows.push_back('{mk(CMD_ASSIGN, OP_SUB, 16'd5, 1'b0, 32'd7, 1'b1, 32'd99), 1'b1,
			mkr(KIND_ASSIGN, OP_ADD, 16'd5, 1'b0, 32'd7, 1'b0, 32'd0, 1'b0)});
		// self assignment at the widest destination
		stim_rows.push_back('{mk(CMD_ASSIGN, OP_ADD, 16'hFFFF, 1'b0, 32'h0000_FFFF, 1'b0, 32'd3),
			1'b1, mkr(KIND_REMOVED, OP_ADD, 16'hFFFF, 1'b0, 32'h0000_FFFF, 1'b0, 32'd0, 1'b1)});
		// upper bits set: not the destination
		stim_rows.push_back('{mk(CMD_ASSIGN, OP_ADD, 16'hFFFF, 1'b0, C_MINUS1, 1'b1, C_MIN), 1'b0, '0});
		// add rules
		stim_rows.push_back('{mk(CMD_ARITH, OP_ADD, 16'd3, 1'b1, 32'd0, 1'b0, 32'd9), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_ADD, 16'd4, 1'b0, 32'd4, 1'b1, 32'd0), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_ADD, 16'd2, 1'b1, -32'sd5, 1'b0, 32'd4), 1'b0, '0});
		// most negative constant: opposite wraps to itself, operator still flips
		stim_rows.push_back('{mk(CMD_ARITH, OP_ADD, 16'd9, 1'b0, 32'd2, 1'b1, C_MIN), 1'b1,
			mkr(KIND_ARITH, OP_SUB, 16'd9, 1'b0, 32'd2, 1'b1, C_MIN, 1'b1)});
		stim_rows.push_back('{mk(CMD_ARITH, OP_ADD, 16'd1, 1'b1, C_MAX, 1'b1, 32'd3), 1'b0, '0});
		// sub rules
		stim_rows.push_back('{mk(CMD_ARITH, OP_SUB, 16'd1, 1'b0, 32'd6, 1'b1, 32'd0), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_SUB, 16'd1, 1'b0, 32'd10, 1'b0, 32'd10), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_SUB, 16'd8, 1'b0, 32'd3, 1'b1, C_MINUS1), 1'b0, '0});
		// mul rules
		stim_rows.push_back('{mk(CMD_ARITH, OP_MUL, 16'd2, 1'b1, 32'd1, 1'b0, 32'd2), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_MUL, 16'd2, 1'b0, 32'd5, 1'b1, 32'd1), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_MUL, 16'd2, 1'b1, 32'd2, 1'b0, 32'd7), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_MUL, 16'd2, 1'b0, 32'd7, 1'b1, 32'd2), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_MUL, 16'd2, 1'b1, C_MINUS1, 1'b0, 32'd6), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_MUL, 16'd2, 1'b0, 32'd6, 1'b1, C_MINUS1), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_MUL, 16'd2, 1'b1, 32'd0, 1'b0, 32'd6), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_MUL, 16'd2, 1'b1, C_MAX, 1'b1, 32'd0), 1'b0, '0});
		// div rules
		stim_rows.push_back('{mk(CMD_ARITH, OP_DIV, 16'd4, 1'b0, 32'd4, 1'b1, 32'd1), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_DIV, 16'd4, 1'b0, 32'd5, 1'b1, C_MINUS1), 1'b0, '0});
		stim_rows.push_back('{mk(CMD_ARITH, OP_DIV, 16'd4, 1'b0, 32'd5, 1'b0, 32'd5), 1'b0, '0});
		// division by zero, and zero divided by a variable
		stim_rows.push_back('{mk(CMD_ARITH, OP_DIV, 16'd7, 1'b0, 32'd3, 1'b1, 32'd0), 1'b1,
			mkr(KIND_ASSIGN, OP_ADD, 16'd7, 1'b1, 32'd0, 1'b0, 32'd0, 1'b1)});
		stim_rows.push_back('{mk(CMD_ARITH, OP_DIV, 16'd7, 1'b1, 32'd0, 1'b0, 32'd4), 1'b0, '0});

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[j]) begin
			push_stmt(stim_rows[j].s, stim_rows[j].typed, stim_rows[j].want);
			n_directed++;
		end

		for (i = 0; i < N_RANDOM; i++) begin
			if (i == HOLD_AT)
				hold_req = 1'b1;
			if (i == DRAIN_AT) begin
				// sender pause until the block has drained
				req_if.valid = 1'b0;
				while (want_q.size() != 0)
					@(posedge clk);
				@(negedge clk);
			end
			if (i == N_RANDOM - QUIET_TAIL)
				quiet = 1'b1;
			push_stmt(rand_stmt(), 1'b0, '0);
		end
		req_if.valid = 1'b0;

		while (want_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("covered %0d statements (%0d directed), %0d results checked, %0d flagged changed",
			n_sent, n_directed, n_checked, n_changed);
		$display("result kinds: %0d arithmetic, %0d assign, %0d removed, %0d passed through",
			n_arith, n_assign, n_removed, n_other);
		if (n_errors == 0 && want_q.size() == 0) begin
			$display("arith_peephole_simplifier: match");
		end else begin
			$display("arith_peephole_simplifier: mismatch");
		end
		$finish;
	end

endmodule

[files.f]
hdl/aps_pkg.sv
hdl/aps_stmt_if.sv
hdl/aps_rslt_if.sv
hdl/aps_rules.sv
hdl/arith_peephole_simplifier.sv
tb/tb_arith_peephole_simplifier.sv
